// ----- rtl/itf_pkg.sv -----
// Shared types, constants and character helpers for the integer to text formatter.
`default_nettype none

package itf_pkg;

   localparam int unsigned MAX_CHARS_DEF = 64;
   localparam int unsigned VAL_W = 32;
   localparam int unsigned NUM_W = 6;
   localparam int unsigned CNT_W = 7;
   localparam int unsigned DIG_BUF_W = 128;

   localparam logic [1:0] CONV_BIN = 2'd0;
   localparam logic [1:0] CONV_DEC = 2'd1;
   localparam logic [1:0] CONV_HEXL = 2'd2;
   localparam logic [1:0] CONV_HEXU = 2'd3;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS = 8'h2b;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_UPPER_A = 8'h41;

   localparam logic [31:0] RECIP_TEN = 32'hcccccccd;
   localparam logic [7:0] TEN = 8'd10;

   typedef struct packed {
      logic start;
      logic pop;
   } itf_dig_ctl_type;

   typedef struct packed {
      logic done;
      logic [NUM_W-1:0] ndig;
      logic [3:0] digit;
   } itf_dig_sts_type;

   function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
      logic [7:0] base;
      base = upper ? CH_UPPER_A : CH_LOWER_A;
      if (d < 4'd10) begin
         digit_char = CH_ZERO + {4'b0, d};
      end else begin
         digit_char = base + {4'b0, d} - TEN;
      end
   endfunction

endpackage

`default_nettype wire

// ----- rtl/itf_digit_unit.sv -----
// Shared digit extraction unit: shifts for binary and hex, reciprocal multiply for decimal.
`default_nettype none

module itf_digit_unit (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire itf_pkg::itf_dig_ctl_type  ctl,
   input  wire logic [1:0]                start_conv,
   input  wire logic [31:0]               start_mag,
   output itf_pkg::itf_dig_sts_type       sts
);
   import itf_pkg::*;

   typedef enum logic [2:0] {
      U_IDLE = 3'b001,
      U_MUL  = 3'b010,
      U_STEP = 3'b100
   } unit_state_type;

   unit_state_type state_ff, state_in;
   logic [VAL_W-1:0] mag_ff, mag_in;
   logic [1:0] conv_ff, conv_in;
   logic [63:0] prod_ff, prod_in;
   logic [DIG_BUF_W-1:0] buf_ff, buf_in;
   logic [NUM_W-1:0] ndig_ff, ndig_in;
   logic done_ff, done_in;

   logic [28:0] quot;
   logic [VAL_W-1:0] rem_full;
   logic [3:0] new_digit;
   logic [VAL_W-1:0] next_mag;

   always_comb begin
      quot = prod_ff[63:35];
      rem_full = mag_ff - ({quot, 3'b000} + {2'b00, quot, 1'b0});
      new_digit = 4'd0;
      next_mag = mag_ff;
      state_in = state_ff;
      mag_in = mag_ff;
      conv_in = conv_ff;
      prod_in = prod_ff;
      buf_in = buf_ff;
      ndig_in = ndig_ff;
      done_in = 1'b0;

      if (ctl.pop) begin
         buf_in = buf_ff << 4;
      end

      unique case (state_ff)
         U_IDLE: begin
            if (ctl.start) begin
               mag_in = start_mag;
               conv_in = start_conv;
               ndig_in = '0;
               state_in = (start_conv == CONV_DEC) ? U_MUL : U_STEP;
            end
         end
         U_MUL: begin
            prod_in = {32'b0, mag_ff} * {32'b0, RECIP_TEN};
            state_in = U_STEP;
         end
         U_STEP: begin
            if (conv_ff == CONV_DEC) begin
               new_digit = rem_full[3:0];
               next_mag = {3'b000, quot};
            end else if (conv_ff == CONV_BIN) begin
               new_digit = {3'b000, mag_ff[0]};
               next_mag = mag_ff >> 1;
            end else begin
               new_digit = mag_ff[3:0];
               next_mag = mag_ff >> 4;
            end
            buf_in = {new_digit, buf_ff[DIG_BUF_W-1:4]};
            mag_in = next_mag;
            ndig_in = ndig_ff + NUM_W'(1);
            if (next_mag == '0) begin
               done_in = 1'b1;
               state_in = U_IDLE;
            end else begin
               state_in = (conv_ff == CONV_DEC) ? U_MUL : U_STEP;
            end
         end
         default: begin
            state_in = U_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
         done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff <= done_in;
      end
      mag_ff <= mag_in;
      conv_ff <= conv_in;
      prod_ff <= prod_in;
      buf_ff <= buf_in;
      ndig_ff <= ndig_in;
   end

   assign sts.done = done_ff;
   assign sts.ndig = ndig_ff;
   assign sts.digit = buf_ff[DIG_BUF_W-1:DIG_BUF_W-4];

endmodule

`default_nettype wire

// ----- rtl/integer_to_text_formatter.sv -----
// Top level of the integer to text formatter: request intake, layout planning and character output.
//
//   Channel | Direction | Handshake          | Payload
//   req     | in        | req_valid/req_stall| value, conversion, flags, width, precision
//   rsp     | out       | rsp_valid/rsp_stall| character, last
//
// Digits come from one shared unit: one digit per cycle for binary and hex, while decimal
// alternates a multiply state and a step state for each digit. The registered done flag and
// the planning states S_PLAN and S_SIZE follow, then one character per cycle moves into the
// output register while the output is not stalled.
// Reset is synchronous and active high and clears the state registers and the done and valid flags.
// A stalled output holds its character; the next item is taken once the final
// character sits in the output register.
`default_nettype none

module integer_to_text_formatter #(
   parameter int unsigned MAX_CHARS = itf_pkg::MAX_CHARS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic signed [31:0] req_value,
   input  wire logic [1:0]         req_conversion,
   input  wire logic               req_plus_flag,
   input  wire logic               req_left_justify,
   input  wire logic               req_zero_fill,
   input  wire logic [5:0]         req_field_width,
   input  wire logic [5:0]         req_min_digits,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [7:0]              rsp_character,
   output logic                    rsp_last
);
   import itf_pkg::*;

   localparam int unsigned REM_W = $clog2(MAX_CHARS + 1);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_DIGITS = 5'b00010,
      S_PLAN   = 5'b00100,
      S_SIZE   = 5'b01000,
      S_EMIT   = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic [1:0] conv_ff, conv_in;
   logic plus_ff, plus_in;
   logic left_ff, left_in;
   logic zfill_ff, zfill_in;
   logic neg_ff, neg_in;
   logic [NUM_W-1:0] width_ff, width_in;
   logic [NUM_W-1:0] prec_ff, prec_in;
   logic [NUM_W-1:0] dig_ff, dig_in;
   logic [NUM_W-1:0] zer_ff, zer_in;
   logic sgn_ff, sgn_in;
   logic [NUM_W-1:0] lead_ff, lead_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_char_ff, rsp_char_in;
   logic rsp_last_ff, rsp_last_in;

   itf_dig_ctl_type dig_ctl;
   itf_dig_sts_type dig_sts;
   logic [31:0] start_mag;
   logic req_neg;
   logic accept;
   logic load_ok;
   logic reserve;
   logic [NUM_W-1:0] target;
   logic [CNT_W-1:0] count;
   logic [NUM_W-1:0] pad;
   logic [CNT_W-1:0] total;

   assign accept = req_valid && !req_stall;
   assign req_neg = (req_conversion == CONV_DEC) && req_value[31];
   assign start_mag = req_neg ? (32'd0 - $unsigned(req_value)) : $unsigned(req_value);
   assign load_ok = !rsp_valid_ff || !rsp_stall;

   itf_digit_unit u_digit (
      .clock      (clock),
      .reset      (reset),
      .ctl        (dig_ctl),
      .start_conv (req_conversion),
      .start_mag  (start_mag),
      .sts        (dig_sts)
   );

   always_comb begin
      reserve = neg_ff || plus_ff;
      if (prec_ff != '0) begin
         target = prec_ff;
      end else if (zfill_ff && (width_ff >= {5'b0, reserve})) begin
         target = width_ff - {5'b0, reserve};
      end else begin
         target = '0;
      end
      count = {1'b0, dig_ff} + {1'b0, zer_ff} + {6'b0, sgn_ff};
      pad = ({1'b0, width_ff} > count) ? (width_ff - count[NUM_W-1:0]) : '0;
      total = count + {1'b0, pad};
   end

   always_comb begin
      state_in = state_ff;
      conv_in = conv_ff;
      plus_in = plus_ff;
      left_in = left_ff;
      zfill_in = zfill_ff;
      neg_in = neg_ff;
      width_in = width_ff;
      prec_in = prec_ff;
      dig_in = dig_ff;
      zer_in = zer_ff;
      sgn_in = sgn_ff;
      lead_in = lead_ff;
      rem_in = rem_ff;
      rsp_char_in = rsp_char_ff;
      rsp_last_in = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      dig_ctl.start = 1'b0;
      dig_ctl.pop = 1'b0;
      req_stall = (state_ff != S_IDLE);

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               conv_in = req_conversion;
               plus_in = req_plus_flag;
               left_in = req_left_justify;
               zfill_in = req_zero_fill;
               neg_in = req_neg;
               width_in = req_field_width;
               prec_in = req_min_digits;
               dig_ctl.start = 1'b1;
               state_in = S_DIGITS;
            end
         end
         S_DIGITS: begin
            if (dig_sts.done) begin
               dig_in = dig_sts.ndig;
               state_in = S_PLAN;
            end
         end
         S_PLAN: begin
            zer_in = (target > dig_ff) ? (target - dig_ff) : '0;
            sgn_in = (conv_ff == CONV_DEC) && (neg_ff || plus_ff);
            state_in = S_SIZE;
         end
         S_SIZE: begin
            lead_in = left_ff ? '0 : pad;
            rem_in = (total > CNT_W'(MAX_CHARS)) ? REM_W'(MAX_CHARS) : REM_W'(total);
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (load_ok) begin
               rsp_valid_in = 1'b1;
               rsp_last_in = (rem_ff == REM_W'(1));
               rem_in = rem_ff - REM_W'(1);
               priority if (lead_ff != '0) begin
                  rsp_char_in = CH_SPACE;
                  lead_in = lead_ff - NUM_W'(1);
               end else if (sgn_ff) begin
                  rsp_char_in = neg_ff ? CH_MINUS : CH_PLUS;
                  sgn_in = 1'b0;
               end else if (zer_ff != '0) begin
                  rsp_char_in = CH_ZERO;
                  zer_in = zer_ff - NUM_W'(1);
               end else if (dig_ff != '0) begin
                  rsp_char_in = digit_char(dig_sts.digit, conv_ff == CONV_HEXU);
                  dig_in = dig_ff - NUM_W'(1);
                  dig_ctl.pop = 1'b1;
               end else begin
                  rsp_char_in = CH_SPACE;
               end
               if (rem_ff == REM_W'(1)) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      conv_ff <= conv_in;
      plus_ff <= plus_in;
      left_ff <= left_in;
      zfill_ff <= zfill_in;
      neg_ff <= neg_in;
      width_ff <= width_in;
      prec_ff <= prec_in;
      dig_ff <= dig_in;
      zer_ff <= zer_in;
      sgn_ff <= sgn_in;
      lead_ff <= lead_in;
      rem_ff <= rem_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_character = rsp_char_ff;
   assign rsp_last = rsp_last_ff;

endmodule

`default_nettype wire

// ----- rtl/itf_checker.sv -----
// Port-level checker for the integer to text formatter and its bind statement.
`default_nettype none

module itf_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_stall,
   input wire logic signed [31:0] req_value,
   input wire logic [1:0]         req_conversion,
   input wire logic               req_plus_flag,
   input wire logic               req_left_justify,
   input wire logic               req_zero_fill,
   input wire logic [5:0]         req_field_width,
   input wire logic [5:0]         req_min_digits,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire logic [7:0]         rsp_character,
   input wire logic               rsp_last
);

   // A stalled item keeps its character and marker.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_character) && $stable(rsp_last))
      else $error("stalled output item changed");

   // Once an item is taken, the block is busy formatting it.
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input not stalled after an item was taken");

   // Only spaces, signs and digit characters ever leave the block.
   a_char_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_character == 8'h20) || (rsp_character == 8'h2b) ||
                    (rsp_character == 8'h2d) ||
                    (rsp_character >= 8'h30 && rsp_character <= 8'h39) ||
                    (rsp_character >= 8'h41 && rsp_character <= 8'h46) ||
                    (rsp_character >= 8'h61 && rsp_character <= 8'h66))
      else $error("unexpected output character");

   // When ready for a new value, any pending output is the final character.
   a_idle_last: assert property (@(posedge clock) disable iff (reset)
      !req_stall && rsp_valid |-> rsp_last)
      else $error("ready for input while text is still being emitted");

endmodule

bind integer_to_text_formatter itf_checker u_itf_checker (.*);

`default_nettype wire

// ----- test/tb_integer_to_text_formatter.sv -----
// Self-checking testbench for the integer to text formatter with its own text predictor.
module tb_integer_to_text_formatter;
   timeunit 1ns;
   timeprecision 1ps;

   import itf_pkg::*;

   localparam int unsigned TEXT_LIMIT = MAX_CHARS_DEF;
   localparam int unsigned IDLE_PERCENT = 31;
   localparam int unsigned RANDOM_COUNT = 338;
   localparam int unsigned SETTLE_CYCLES = 80;
   localparam logic [7:0] ASCII_ZERO = "0";
   localparam logic [7:0] ASCII_SPACE = " ";
   localparam logic [7:0] ASCII_MINUS = "-";
   localparam logic [7:0] ASCII_PLUS = "+";
   localparam logic [7:0] ASCII_LC_A = "a";
   localparam logic [7:0] ASCII_UC_A = "A";

   typedef struct {
      logic [31:0] value;
      logic [1:0]  conversion;
      logic        plus_flag;
      logic        left_justify;
      logic        zero_fill;
      logic [5:0]  field_width;
      logic [5:0]  min_digits;
      logic        wait_drain;
   } format_request_type;

   typedef struct {
      logic [7:0] character;
      logic       last;
   } text_char_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [31:0] req_value = '0;
   logic [1:0] req_conversion = CONV_BIN;
   logic req_plus_flag = 1'b0;
   logic req_left_justify = 1'b0;
   logic req_zero_fill = 1'b0;
   logic [5:0] req_field_width = '0;
   logic [5:0] req_min_digits = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [7:0] rsp_character;
   logic rsp_last;

   format_request_type pending_requests[$];
   text_char_type expected_text[$];
   int unsigned items_accepted = 0;
   int unsigned chars_checked = 0;
   int unsigned mismatches = 0;
   int unsigned conv_seen[4] = '{0, 0, 0, 0};
   logic quiet_window = 1'b0;
   logic text_drained = 1'b1;

   integer_to_text_formatter i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_value(req_value),
      .req_conversion(req_conversion),
      .req_plus_flag(req_plus_flag),
      .req_left_justify(req_left_justify),
      .req_zero_fill(req_zero_fill),
      .req_field_width(req_field_width),
      .req_min_digits(req_min_digits),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_character(rsp_character),
      .rsp_last(rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void predict_text(input format_request_type r);
      logic [31:0] mag;
      logic [7:0] rev [0:159];
      logic [7:0] line_buf [0:159];
      logic neg;
      int unsigned radix, digit, count, total, pad, reserve, emit, i;
      mag = r.value;
      neg = 1'b0;
      count = 0;
      total = 0;
      case (r.conversion)
         CONV_BIN: radix = 2;
         CONV_DEC: begin
            radix = 10;
            if (mag[31]) begin
               neg = 1'b1;
               mag = 32'd0 - mag;
            end
         end
         default: radix = 16;
      endcase
      do begin
         digit = mag % radix;
         if (digit < 10)
            rev[count] = ASCII_ZERO + 8'(digit);
         else
            rev[count] = (r.conversion == CONV_HEXU ? ASCII_UC_A : ASCII_LC_A)
                         + 8'(digit - 10);
         count = count + 1;
         mag = mag / radix;
      end while (mag != 0);
      while (r.min_digits > count) begin
         rev[count] = ASCII_ZERO;
         count = count + 1;
      end
      if (r.min_digits == 0 && r.zero_fill) begin
         reserve = (neg || r.plus_flag) ? 1 : 0;
         while (r.field_width > count + reserve) begin
            rev[count] = ASCII_ZERO;
            count = count + 1;
         end
      end
      if (r.conversion == CONV_DEC) begin
         if (neg) begin
            rev[count] = ASCII_MINUS;
            count = count + 1;
         end else if (r.plus_flag) begin
            rev[count] = ASCII_PLUS;
            count = count + 1;
         end
      end
      pad = (r.field_width > count) ? r.field_width - count : 0;
      if (!r.left_justify) begin
         for (i = 0; i < pad; i++) begin
            line_buf[total] = ASCII_SPACE;
            total = total + 1;
         end
      end
      for (i = 0; i < count; i++) begin
         line_buf[total] = rev[count - 1 - i];
         total = total + 1;
      end
      if (r.left_justify) begin
         for (i = 0; i < pad; i++) begin
            line_buf[total] = ASCII_SPACE;
            total = total + 1;
         end
      end
      emit = (total > TEXT_LIMIT) ? TEXT_LIMIT : total;
      for (i = 0; i < emit; i++)
         expected_text.push_back('{line_buf[i], i + 1 == emit});
   endfunction

   task automatic queue_request(input logic [31:0] value, input logic [1:0] conversion,
                                input logic plus_flag, input logic left_justify,
                                input logic zero_fill, input logic [5:0] field_width,
                                input logic [5:0] min_digits);
      pending_requests.push_back('{value, conversion, plus_flag, left_justify, zero_fill,
                                   field_width, min_digits, 1'b0});
   endtask

   always @(posedge clock) begin : drive_requests
      format_request_type next_req;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (pending_requests.size() != 0
             && (quiet_window || $urandom_range(99) >= IDLE_PERCENT)
             && !(pending_requests[0].wait_drain && (req_valid || !text_drained))) begin
            next_req = pending_requests.pop_front();
            req_valid <= 1'b1;
            req_value <= next_req.value;
            req_conversion <= next_req.conversion;
            req_plus_flag <= next_req.plus_flag;
            req_left_justify <= next_req.left_justify;
            req_zero_fill <= next_req.zero_fill;
            req_field_width <= next_req.field_width;
            req_min_digits <= next_req.min_digits;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= !quiet_window && ($urandom_range(99) < IDLE_PERCENT);
   end

   always @(posedge clock) begin : watch_channels
      text_char_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predict_text('{req_value, req_conversion, req_plus_flag, req_left_justify,
                           req_zero_fill, req_field_width, req_min_digits, 1'b0});
            conv_seen[req_conversion] = conv_seen[req_conversion] + 1;
            items_accepted = items_accepted + 1;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_text.size() == 0) begin
               mismatches = mismatches + 1;
               $display("%0t: unexpected item: expected none, got character 8'h%h last %b",
                        $time, rsp_character, rsp_last);
            end else begin
               want = expected_text.pop_front();
               if (rsp_character !== want.character) begin
                  mismatches = mismatches + 1;
                  $display("%0t: character %0d: expected 8'h%h, got 8'h%h",
                           $time, chars_checked, want.character, rsp_character);
               end
               if (rsp_last !== want.last) begin
                  mismatches = mismatches + 1;
                  $display("%0t: last flag of character %0d: expected %b, got %b",
                           $time, chars_checked, want.last, rsp_last);
               end
               chars_checked = chars_checked + 1;
            end
         end
         quiet_window <= items_accepted >= 150 && items_accepted < 215;
         text_drained <= expected_text.size() == 0;
      end
   end

   initial begin : run_regression
      format_request_type r;
      int unsigned i, total_items;
      queue_request(32'd0, CONV_DEC, 1'b0, 1'b0, 1'b0, 6'd0, 6'd0);
      queue_request(32'd0, CONV_BIN, 1'b0, 1'b0, 1'b1, 6'd5, 6'd0);
      queue_request(32'd0, CONV_HEXL, 1'b0, 1'b1, 1'b0, 6'd4, 6'd3);
      queue_request(32'h8000_0000, CONV_DEC, 1'b0, 1'b0, 1'b0, 6'd0, 6'd0);
      queue_request(32'h7fff_ffff, CONV_DEC, 1'b1, 1'b0, 1'b0, 6'd0, 6'd0);
      queue_request(32'hffff_ffff, CONV_BIN, 1'b0, 1'b0, 1'b0, 6'd0, 6'd0);
      queue_request(32'hffff_ffff, CONV_HEXL, 1'b0, 1'b0, 1'b0, 6'd0, 6'd0);
      queue_request(32'hdead_beef, CONV_HEXU, 1'b0, 1'b0, 1'b0, 6'd12, 6'd0);
      queue_request(32'h00ab_cdef, CONV_HEXL, 1'b1, 1'b0, 1'b1, 6'd10, 6'd0);
      queue_request(32'hffff_ffd6, CONV_DEC, 1'b0, 1'b0, 1'b1, 6'd12, 6'd0);
      queue_request(32'd42, CONV_DEC, 1'b1, 1'b0, 1'b1, 6'd8, 6'd0);
      queue_request(32'd42, CONV_DEC, 1'b0, 1'b0, 1'b1, 6'd8, 6'd4);
      queue_request(32'd1234, CONV_DEC, 1'b0, 1'b1, 1'b0, 6'd20, 6'd0);
      queue_request(32'hffff_ffff, CONV_DEC, 1'b0, 1'b0, 1'b0, 6'd63, 6'd63);
      queue_request(32'd5, CONV_BIN, 1'b1, 1'b1, 1'b0, 6'd63, 6'd63);
      queue_request(32'h8000_0000, CONV_DEC, 1'b0, 1'b0, 1'b1, 6'd63, 6'd0);
      queue_request(32'hffff_ffff, CONV_BIN, 1'b0, 1'b1, 1'b1, 6'd63, 6'd0);
      queue_request(32'd7, CONV_BIN, 1'b1, 1'b0, 1'b1, 6'd6, 6'd0);
      queue_request(32'd123_456_789, CONV_DEC, 1'b0, 1'b0, 1'b0, 6'd3, 6'd2);
      queue_request(32'd0, CONV_DEC, 1'b1, 1'b0, 1'b1, 6'd5, 6'd0);
      queue_request(32'd0, CONV_HEXU, 1'b0, 1'b1, 1'b0, 6'd63, 6'd0);
      queue_request(32'h0000_00ff, CONV_HEXU, 1'b1, 1'b0, 1'b0, 6'd1, 6'd63);
      for (i = 0; i < RANDOM_COUNT; i++) begin
         case ($urandom_range(5))
            0: r.value = $urandom_range(9);
            1: r.value = 32'd0 - $urandom_range(1000, 1);
            2: r.value = 32'd1 << $urandom_range(31);
            3: r.value = $urandom_range(1) ? 32'h8000_0000 + $urandom_range(15)
                                           : 32'h7fff_ffff - $urandom_range(15);
            default: r.value = $urandom;
         endcase
         r.conversion = 2'($urandom_range(3));
         r.plus_flag = 1'($urandom_range(1));
         r.left_justify = 1'($urandom_range(1));
         r.zero_fill = 1'($urandom_range(1));
         r.field_width = ($urandom_range(3) == 0) ? 6'($urandom_range(63, 40))
                                                  : 6'($urandom_range(24));
         case ($urandom_range(9))
            0, 1, 2, 3, 4: r.min_digits = 6'd0;
            5, 6, 7: r.min_digits = 6'($urandom_range(12));
            default: r.min_digits = 6'($urandom_range(63));
         endcase
         r.wait_drain = (i % 90 == 0);
         pending_requests.push_back(r);
      end
      total_items = pending_requests.size();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      while (items_accepted < total_items || expected_text.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Checked %0d characters from %0d values: binary %0d, decimal %0d, hex %0d/%0d.",
               chars_checked, items_accepted, conv_seen[CONV_BIN], conv_seen[CONV_DEC],
               conv_seen[CONV_HEXL], conv_seen[CONV_HEXU]);
      $display("Signs, zero fill, precision and justification were exercised; %0d mismatches.",
               mismatches);
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timed out with %0d values accepted and %0d characters still expected.",
               items_accepted, expected_text.size());
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
